// ----- src/assert_macros.svh -----
// Assertion macros shared by the timer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

// ----- src/ptlt_pkg.sv -----
// Shared types, codes and helpers of the tick/tock timer.
// Depends on nothing; imported by every timer module.
`default_nettype none

package ptlt_pkg;

  localparam logic [15:0] INTERVAL_RESET = 16'd20000;
  localparam logic signed [15:0] OFS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] OFS_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    CMD_TIME_PASS = 3'd0,
    CMD_SET_PHASE = 3'd1,
    CMD_OFS_UP    = 3'd2,
    CMD_OFS_DOWN  = 3'd3,
    CMD_OFS_CLEAR = 3'd4,
    CMD_STOP      = 3'd5,
    CMD_RESUME    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TICK = 2'd1,
    EV_TOCK = 2'd2
  } event_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [16:0] phase_shift_value;
  } item_t;

  // Packed so that the first field lands in the highest bits.
  typedef struct packed {
    logic signed [15:0] phase_shift_now;
    logic signed [15:0] freq_offset_now;
    logic               is_running;
    logic [1:0]         event_res;
  } result_t;

  // A period below one microsecond is raised to one.
  function automatic logic [16:0] at_least_one(input logic signed [17:0] p);
    logic [16:0] r;
    if (p < 18'sd1) begin
      r = 17'd1;
    end else begin
      r = p[16:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/phase_locked_tick_tock_timer_core.sv -----
// Top level of the tick/tock half-period timer with its configuration register.
// Depends on ptlt_pkg, ptlt_in_reg, ptlt_step, ptlt_out_reg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Tick/tock half-period timer. Each request on the input stream is either one
// elapsed microsecond or a command (set phase shift, frequency offset up, down
// or clear, stop, resume). The command code travels in in_tuser and the
// requested phase shift in in_tdata. Every request yields exactly one result
// that reports whether a tick or a tock fired, whether the timer runs, and the
// frequency offset and pending phase shift after the request. The block takes
// one request per clock cycle as long as the consumer keeps out_tready high:
// a request is held in the input register, the update logic works on it in a
// single pass, and the result is captured in the output register. When the
// consumer stalls, one result waits in the output register and one more
// request can still be taken into the input register. The interval register
// (reset 20000) is written through the cfg port at any time the stream is
// idle; half of it is the nominal half period and the phase shift clamp.
// cfg_ready is always high.
module phase_locked_tick_tock_timer_core import ptlt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [16:0] phase_shift_value, [23:17] zero
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [1:0] event_res, [2] is_running,
                                       // [18:3] freq_offset_now,
                                       // [34:19] phase_shift_now, [39:35] zero
  // Configuration write channel for interval_us.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] interval_r, interval_nxt;
  item_t       in_item, cur_item;
  result_t     step_res, out_res;
  logic        item_vld, space, advance;

  // The register is always writable.
  assign cfg_ready    = 1'b1;
  assign interval_nxt = (cfg_valid && cfg_ready) ? cfg_data : interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else begin
      interval_r <= interval_nxt;
    end
  end

  assign in_item.command           = in_tuser;
  assign in_item.phase_shift_value = $signed(in_tdata[16:0]);

  // A held request moves on whenever the result register has room.
  assign advance = item_vld && space;

  ptlt_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .in_ready (in_tready),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (cur_item)
  );

  ptlt_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (cur_item),
    .interval_us (interval_r),
    .result      (step_res)
  );

  ptlt_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (step_res),
    .space      (space),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_res)
  );

  assign out_tdata = {5'b00000, out_res};

  // Backpressure only reaches the input when both registers are occupied.
  `PTLT_ASSERT_NOW(a_stall_source, clk, rst_n, !in_tready,
    item_vld && out_tvalid && !out_tready)
  // A stopped timer never reports an event.
  `PTLT_ASSERT_NOW(a_no_event_stopped, clk, rst_n, out_tvalid && !out_res.is_running,
    out_res.event_res == EV_NONE)
  // A tock consumes the pending phase shift.
  `PTLT_ASSERT_NOW(a_tock_clears_shift, clk, rst_n,
    out_tvalid && out_res.event_res == EV_TOCK, out_res.phase_shift_now == 16'sd0)
  // A request that moves on from the input register always produces a result in the following cycle.
  `PTLT_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_tvalid)

endmodule

`default_nettype wire

// ----- src/ptlt_in_reg.sv -----
// Input register of the timer: holds one accepted request for the step logic.
// Depends on ptlt_pkg.
`default_nettype none

module ptlt_in_reg import ptlt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       in_ready,
  input  wire logic  advance,
  output logic       item_vld,
  output item_t      item
);

  logic  vld_r, vld_nxt;
  item_t item_r;

  assign in_ready = !vld_r || advance;
  assign vld_nxt  = in_valid ? 1'b1 : (advance ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// ----- src/ptlt_step.sv -----
// Timer state and the single-pass update applied to one request.
// Depends on ptlt_pkg.
`default_nettype none

module ptlt_step import ptlt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire item_t       item,
  input  wire logic [15:0] interval_us,
  output result_t          result
);

  logic               running_r, running_nxt;
  logic               next_is_tick_r, next_is_tick_nxt;
  logic [16:0]        remaining_r, remaining_nxt;
  logic signed [15:0] ofs_r, ofs_nxt;
  logic signed [15:0] pps_r, pps_nxt;

  logic [14:0]        half;
  logic signed [17:0] half_s, ofs_s, pps_s, req_s;
  logic signed [17:0] tick_period, tock_period, clamped;
  logic [1:0]         ev;

  assign half        = interval_us[15:1];
  assign half_s      = $signed({3'b000, half});
  assign ofs_s       = {{2{ofs_r[15]}}, ofs_r};
  assign pps_s       = {{2{pps_r[15]}}, pps_r};
  assign req_s       = {item.phase_shift_value[16], item.phase_shift_value};
  assign tick_period = half_s + ofs_s;
  assign tock_period = half_s + pps_s + ofs_s;

  always_comb begin
    if (req_s > half_s) begin
      clamped = half_s;
    end else if (req_s < -half_s) begin
      clamped = -half_s;
    end else begin
      clamped = req_s;
    end
  end

  always_comb begin
    running_nxt      = running_r;
    next_is_tick_nxt = next_is_tick_r;
    remaining_nxt    = remaining_r;
    ofs_nxt          = ofs_r;
    pps_nxt          = pps_r;
    ev               = EV_NONE;
    unique case (item.command)
      CMD_TIME_PASS: begin
        if (running_r) begin
          if (remaining_r > 17'd1) begin
            remaining_nxt = remaining_r - 17'd1;
          end else if (next_is_tick_r) begin
            ev               = EV_TICK;
            next_is_tick_nxt = 1'b0;
            remaining_nxt    = at_least_one(tick_period);
          end else begin
            ev               = EV_TOCK;
            next_is_tick_nxt = 1'b1;
            pps_nxt          = '0;
            remaining_nxt    = at_least_one(tock_period);
          end
        end
      end
      CMD_SET_PHASE: pps_nxt = clamped[15:0];
      CMD_OFS_UP: begin
        if (ofs_r != OFS_MAX) begin
          ofs_nxt = ofs_r + 16'sd1;
        end
      end
      CMD_OFS_DOWN: begin
        if (ofs_r != OFS_MIN) begin
          ofs_nxt = ofs_r - 16'sd1;
        end
      end
      CMD_OFS_CLEAR: ofs_nxt = '0;
      CMD_STOP: begin
        running_nxt   = 1'b0;
        remaining_nxt = '0;
      end
      CMD_RESUME: begin
        running_nxt      = 1'b1;
        next_is_tick_nxt = 1'b0;
        remaining_nxt    = (half == 15'd0) ? 17'd1 : {2'b00, half};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r      <= 1'b0;
      next_is_tick_r <= 1'b0;
      remaining_r    <= '0;
      ofs_r          <= '0;
      pps_r          <= '0;
    end else if (advance) begin
      running_r      <= running_nxt;
      next_is_tick_r <= next_is_tick_nxt;
      remaining_r    <= remaining_nxt;
      ofs_r          <= ofs_nxt;
      pps_r          <= pps_nxt;
    end
  end

  assign result.event_res       = ev;
  assign result.is_running      = running_nxt;
  assign result.freq_offset_now = ofs_nxt;
  assign result.phase_shift_now = pps_nxt;

endmodule

`default_nettype wire

// ----- src/ptlt_out_reg.sv -----
// Result register of the timer: holds one finished result for the consumer.
// Depends on ptlt_pkg.
`default_nettype none

module ptlt_out_reg import ptlt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign space   = !vld_r || out_ready;
  assign vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid  = vld_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

// ----- verif/phase_locked_tick_tock_timer_core_tb.sv -----
// Self-checking testbench for the tick/tock half-period timer core.
// Depends on ptlt_pkg and phase_locked_tick_tock_timer_core; needs nothing else.
`timescale 1ns / 100ps

module phase_locked_tick_tock_timer_core_tb;
  import ptlt_pkg::*;

  // The command code 7 is not part of cmd_t; the block must treat it as a no-op.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Cycles without any handshake on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Extra margin before a register write or the end.
  localparam int SETTLE_CYCLES = 6;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [16:0] phase_shift_value, [23:17] zero
  logic [2:0]  in_tuser = '0;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [1:0] event_res, [2] is_running, [18:3] freq_offset_now,
                                // [34:19] phase_shift_now, [39:35] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  phase_locked_tick_tock_timer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Percentages of cycles in which the sender holds back a request and the
  // receiver deasserts out_tready. They change between the three traffic phases.
  int src_idle_pct  = 13;
  int sink_idle_pct = 58;

  // The receiver redraws its ready every cycle, so stalls land on every phase
  // of the timer's work, including the cycle in which an event fires.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Timer predictor. It keeps its own copy of the timer state and the interval
  // register, and is stepped once for every request accepted on the input.
  // ---------------------------------------------------------------------------
  logic [15:0] interval_reg  = INTERVAL_RESET;
  bit          timer_running = 1'b0;
  bit          tick_is_next  = 1'b0;   // a tock always comes first after resume
  int          us_left       = 0;
  int          freq_ofs      = 0;
  int          phase_pending = 0;

  // A period that the offset drives below one microsecond is raised to one.
  function automatic int floor_to_one(input int period);
    return (period < 1) ? 1 : period;
  endfunction

  function automatic result_t predict_timer_result(input logic [2:0] cmd,
                                                   input logic signed [16:0] req_raw);
    int      half;
    int      req;
    event_t  fired;
    result_t res;
    half  = int'({16'd0, interval_reg}) / 2;
    req   = int'(req_raw);
    fired = EV_NONE;
    case (cmd)
      CMD_TIME_PASS: begin
        // Time only counts while running; a count of one or less means fire now.
        if (timer_running) begin
          if (us_left > 1) begin
            us_left = us_left - 1;
          end else if (tick_is_next) begin
            fired        = EV_TICK;
            us_left      = floor_to_one(half + freq_ofs);
            tick_is_next = 1'b0;
          end else begin
            // The pending phase shift is spent on the half period after a tock.
            fired         = EV_TOCK;
            us_left       = floor_to_one(half + phase_pending + freq_ofs);
            phase_pending = 0;
            tick_is_next  = 1'b1;
          end
        end
      end
      CMD_SET_PHASE: begin
        // Clamped against the interval as it stands now, never re-clamped later.
        if (req > half) req = half;
        if (req < -half) req = -half;
        phase_pending = req;
      end
      CMD_OFS_UP: begin
        if (freq_ofs < 32767) freq_ofs = freq_ofs + 1;
      end
      CMD_OFS_DOWN: begin
        if (freq_ofs > -32768) freq_ofs = freq_ofs - 1;
      end
      CMD_OFS_CLEAR: begin
        freq_ofs = 0;
      end
      CMD_STOP: begin
        timer_running = 1'b0;
        us_left       = 0;
      end
      CMD_RESUME: begin
        // Resume restarts even a running timer, with a tock half an interval out.
        tick_is_next  = 1'b0;
        timer_running = 1'b1;
        us_left       = floor_to_one(half);
      end
      default: begin
      end
    endcase
    res.event_res       = fired;
    res.is_running      = timer_running;
    res.freq_offset_now = freq_ofs[15:0];
    res.phase_shift_now = phase_pending[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Expected results wait in order of acceptance; each result
  // that leaves the block is compared field by field with the oldest one.
  // ---------------------------------------------------------------------------
  result_t pending_results[$];
  int      mismatch_count = 0;

  // Directed rows with a result typed into the table carry it alongside the
  // request; the monitor then queues that value instead of the predicted one.
  bit      use_fixed = 1'b0;
  result_t fixed_result = '0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        interval_reg = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        want = predict_timer_result(in_tuser, in_tdata[16:0]);
        if (use_fixed) want = fixed_result;
        pending_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[34:0];
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.event_res != want.event_res)
            report_mismatch($sformatf("event_res got %0d expected %0d",
                                      got.event_res, want.event_res));
          if (got.is_running != want.is_running)
            report_mismatch($sformatf("is_running got %0d expected %0d",
                                      got.is_running, want.is_running));
          if (got.freq_offset_now != want.freq_offset_now)
            report_mismatch($sformatf("freq_offset_now got %0d expected %0d",
                                      got.freq_offset_now, want.freq_offset_now));
          if (got.phase_shift_now != want.phase_shift_now)
            report_mismatch($sformatf("phase_shift_now got %0d expected %0d",
                                      got.phase_shift_now, want.phase_shift_now));
        end
      end
    end
  end

  // The watchdog only counts cycles in which no channel completes a handshake,
  // so a long but healthy run never trips it.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All are entered right after a rising edge and drive with
  // nonblocking assignments. in_tvalid stays high between back-to-back
  // requests and is lowered only when a gap or a pause actually follows.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] cmd, input logic signed [16:0] value,
                              input bit fixed, input result_t want);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= cmd;
    in_tdata     <= {7'd0, value};
    use_fixed    <= fixed;
    fixed_result <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drops the request line and lets every outstanding result drain, so the
  // interval register is only touched while the timer core is idle. It first
  // waits for a rising edge so that the last accepted request is surely queued.
  task automatic wait_for_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random requests lean heavily on elapsed microseconds so events keep firing,
  // with the commands mixed in. Phase values are any 17-bit pattern half of the
  // time, and otherwise near the clamp window or right at its edges.
  task automatic issue_random_request(input int half);
    int         pick;
    int         req;
    logic [2:0] cmd;
    pick = $urandom_range(99);
    req  = int'($urandom_range(131071)) - 65536;
    if (pick < 66) begin
      cmd = CMD_TIME_PASS;
    end else if (pick < 76) begin
      cmd = CMD_SET_PHASE;
      case ($urandom_range(3))
        0: req = int'($urandom_range(2 * half + 4)) - half - 2;
        1: begin
          case ($urandom_range(5))
            0: req = -65536;
            1: req = 65535;
            2: req = half;
            3: req = -half;
            4: req = half + 1;
            default: req = -half - 1;
          endcase
        end
        default: begin
        end
      endcase
    end else if (pick < 83) begin
      cmd = CMD_OFS_UP;
    end else if (pick < 90) begin
      cmd = CMD_OFS_DOWN;
    end else if (pick < 93) begin
      cmd = CMD_OFS_CLEAR;
    end else if (pick < 95) begin
      cmd = CMD_STOP;
    end else if (pick < 99) begin
      cmd = CMD_RESUME;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, req[16:0], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows up to the first register write run at the reset
  // interval of 20000, so the clamp is plus or minus 10000 and the expected
  // result can be typed in. Later rows use tiny intervals (firing after a
  // couple of microseconds, a zero half interval) and the widest one, and are
  // checked against the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit         is_cfg;
    logic [2:0] cmd;
    int         arg;      // phase value for a request, interval for a write
    bit         fixed;
    event_t     w_event;
    bit         w_running;
    int         w_offset;
    int         w_phase;
  } directed_row_t;

  directed_row_t directed_rows [0:27] = '{
    // Stopped after reset: time does not count, the unused code is a no-op.
    '{1'b0, CMD_TIME_PASS, 0,      1'b1, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_UNUSED,    -1,     1'b1, EV_NONE, 1'b0, 0,  0},
    // Phase shifts at both field extremes are clamped to half the interval.
    '{1'b0, CMD_SET_PHASE, 65535,  1'b1, EV_NONE, 1'b0, 0,  10000},
    '{1'b0, CMD_SET_PHASE, -65536, 1'b1, EV_NONE, 1'b0, 0,  -10000},
    // Offset commands act while stopped; a repeated stop changes nothing.
    '{1'b0, CMD_OFS_UP,    0,      1'b1, EV_NONE, 1'b0, 1,  -10000},
    '{1'b0, CMD_OFS_DOWN,  0,      1'b1, EV_NONE, 1'b0, 0,  -10000},
    '{1'b0, CMD_OFS_DOWN,  0,      1'b1, EV_NONE, 1'b0, -1, -10000},
    '{1'b0, CMD_STOP,      0,      1'b1, EV_NONE, 1'b0, -1, -10000},
    '{1'b0, CMD_OFS_CLEAR, 0,      1'b1, EV_NONE, 1'b0, 0,  -10000},
    '{1'b0, CMD_RESUME,    0,      1'b1, EV_NONE, 1'b1, 0,  -10000},
    '{1'b0, CMD_STOP,      0,      1'b1, EV_NONE, 1'b0, 0,  -10000},
    // Interval 5: half period 2, so a tock fires on the second pass after each resume.
    '{1'b1, CMD_TIME_PASS, 5,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_SET_PHASE, 3,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_RESUME,    0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_RESUME,    0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    // Interval 0: the resume period and every negative period become one.
    '{1'b1, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_RESUME,    0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_OFS_DOWN,  0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_TIME_PASS, 0,      1'b0, EV_NONE, 1'b0, 0,  0},
    // Widest interval: the clamp opens to plus or minus 32767.
    '{1'b1, CMD_TIME_PASS, 65535,  1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_SET_PHASE, -65536, 1'b0, EV_NONE, 1'b0, 0,  0},
    '{1'b0, CMD_STOP,      0,      1'b0, EV_NONE, 1'b0, 0,  0}
  };

  initial begin : stimulus
    result_t     typed_result;
    logic [15:0] interval_pick;
    int          half;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the first traffic setting.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_for_quiet();
        write_interval(directed_rows[i].arg[15:0]);
      end else begin
        typed_result.event_res       = directed_rows[i].w_event;
        typed_result.is_running      = directed_rows[i].w_running;
        typed_result.freq_offset_now = directed_rows[i].w_offset[15:0];
        typed_result.phase_shift_now = directed_rows[i].w_phase[15:0];
        send_request(directed_rows[i].cmd, directed_rows[i].arg[16:0],
                     directed_rows[i].fixed, typed_result);
      end
    end

    // Random part in three traffic phases: a slow receiver, then a slow sender,
    // then full rate. Each phase walks four interval settings, from the extremes
    // through small ones where events fire often, to wide ones.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 58 : 0;
      sink_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 13 : 0;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: interval_pick = (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1 : 16'hFFFF;
          1: interval_pick = 16'($urandom_range(2, 12));
          2: interval_pick = 16'($urandom_range(13, 80));
          default: interval_pick = (ph == 2) ? INTERVAL_RESET : 16'($urandom_range(65535));
        endcase
        wait_for_quiet();
        write_interval(interval_pick);
        half = int'({16'd0, interval_pick}) / 2;
        repeat (145) issue_random_request(half);
      end
    end

    // Drain, then give a stray extra result time to show up.
    wait_for_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ptlt_pkg.sv
src/ptlt_in_reg.sv
src/ptlt_step.sv
src/ptlt_out_reg.sv
src/phase_locked_tick_tock_timer_core.sv
verif/phase_locked_tick_tock_timer_core_tb.sv
